@@ rtl/basp_pkg.sv @@
// basp_pkg: shared types and constants for the binary array stream parser
// holds phase, event and error encodings and the fixed tag bytes
// no dependencies
package basp_pkg;

  localparam int unsigned MAX_VARIABLES = 16;
  localparam int unsigned VAR_W = 5;

  localparam logic [7:0] MARKER_B    = 8'h62;
  localparam logic [7:0] VERSION_2   = 8'h02;
  localparam logic [7:0] WS_SPACE    = 8'h20;
  localparam logic [7:0] WS_NUL      = 8'h00;
  localparam logic [7:0] WS_TAB      = 8'h09;
  localparam logic [7:0] WS_NEWLINE  = 8'h0a;

  // tag bytes in stream order: " i32" and " f32"
  localparam logic [7:0] TAG_INT [4] = '{8'h20, 8'h69, 8'h33, 8'h32};
  localparam logic [7:0] TAG_FLT [4] = '{8'h20, 8'h66, 8'h33, 8'h32};

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_VERSION = 3'd1,
    PH_RANK    = 3'd2,
    PH_TAG     = 3'd3,
    PH_DIM     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_SKIP      = 3'd0,
    EV_HEADER    = 3'd1,
    EV_DIM_DONE  = 3'd2,
    EV_PAYLOAD   = 3'd3,
    EV_ELEM_DONE = 3'd4,
    EV_STREAM    = 3'd5,
    EV_ERROR     = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MARKER    = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_TYPE      = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_TOO_MANY  = 3'd5,
    ERR_OVERFLOW  = 3'd6
  } err_t;

  localparam logic [1:0] TAG_BOTH = 2'b11;
  localparam logic [1:0] TAG_FLT_ONLY = 2'b10;

endpackage

@@ rtl/binary_array_stream_parser_unit.sv @@
// The result of an accepted request is in the output register in the next cycle.
// One byte is taken per cycle while in_stall is low; the dimension product is built one 64x8 partial
// product per dimension byte, so no cycle needs more than one narrow multiply.
// in_stall is raised only while a result waits and out_stall holds it.
// Reset (synchronous, rst_n low) returns the parser to whitespace skipping,
// clears the latched error and the variable count, and empties the output.
module binary_array_stream_parser_unit
  import basp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_stream,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_event_code,
  output logic [2:0]        out_error_code,
  output logic [VAR_W-1:0]  out_variable_number,
  output logic              out_element_type,
  output logic [7:0]        out_rank,
  output logic [7:0]        out_dimension_index,
  output logic [63:0]       out_dimension_size,
  output logic [31:0]       out_element_bits,
  output logic [63:0]       out_element_total,
  output logic              out_variable_done
);

  // parser state
  phase_t             phase_r, phase_nxt;
  err_t               lerr_r, lerr_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [7:0]         rank_r, rank_nxt;
  logic [7:0]         dleft_r, dleft_nxt;
  logic [63:0]        dshift_r, dshift_nxt;
  logic [63:0]        cprod_r, cprod_nxt;
  logic [63:0]        eleft_r, eleft_nxt;
  logic [31:0]        eshift_r, eshift_nxt;
  logic [1:0]         tag_r, tag_nxt;
  logic [VAR_W-1:0]   vcnt_r, vcnt_nxt;
  // running product of the element count so far and the dimension being read
  logic [63:0]        acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;

  // output register
  logic               out_valid_r;
  logic [2:0]         ev_r, err_r;
  logic [VAR_W-1:0]   vn_r;
  logic               etype_r;
  logic [7:0]         rank_out_r, didx_r;
  logic [63:0]        dsz_r, total_r;
  logic [31:0]        bits_r;
  logic               vdone_r;

  // step results
  event_t             ev;
  err_t               err;
  logic [VAR_W-1:0]   vn;
  logic [7:0]         didx;
  logic [63:0]        dsz;
  logic [31:0]        bits;
  logic               vdone;

  logic               in_acc;
  logic [71:0]        mul;
  logic [135:0]       term_sh;
  logic [64:0]        acc_sum;
  logic               ovf_fin;
  logic [63:0]        dim_val;
  logic [31:0]        elem_val;
  logic [63:0]        eleft_dec;
  logic [1:0]         tag_upd;
  logic               is_ws;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  // one 64x8 partial product per dimension byte, placed at its byte lane
  assign mul     = cprod_r * {64'd0, in_data_byte};
  assign term_sh = {64'd0, mul} << {pos_r, 3'b000};
  assign acc_sum = {1'b0, acc_r} + {1'b0, term_sh[63:0]};
  assign ovf_fin = ovf_r || acc_sum[64] || (|term_sh[135:64]);

  assign dim_val   = dshift_r | ({56'd0, in_data_byte} << {pos_r, 3'b000});
  assign elem_val  = eshift_r | ({24'd0, in_data_byte} << {pos_r[1:0], 3'b000});
  assign eleft_dec = eleft_r - 64'd1;
  assign is_ws = (in_data_byte == WS_SPACE) || (in_data_byte == WS_NUL) ||
                 (in_data_byte == WS_TAB) || (in_data_byte == WS_NEWLINE);

  always_comb begin
    phase_nxt  = phase_r;
    lerr_nxt   = lerr_r;
    pos_nxt    = pos_r;
    rank_nxt   = rank_r;
    dleft_nxt  = dleft_r;
    dshift_nxt = dshift_r;
    cprod_nxt  = cprod_r;
    eleft_nxt  = eleft_r;
    eshift_nxt = eshift_r;
    tag_nxt    = tag_r;
    vcnt_nxt   = vcnt_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    ev    = EV_SKIP;
    err   = ERR_NONE;
    vn    = vcnt_r;
    didx  = 8'd0;
    dsz   = 64'd0;
    bits  = 32'd0;
    vdone = 1'b0;
    tag_upd = tag_r;

    if (lerr_r == ERR_NONE) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (is_ws) begin
            ev = EV_SKIP;
          end else if (in_data_byte == MARKER_B) begin
            if (vcnt_r >= VAR_W'(MAX_VARIABLES)) begin
              err = ERR_TOO_MANY;
            end else begin
              ev        = EV_HEADER;
              phase_nxt = PH_VERSION;
              rank_nxt  = 8'd0;
              dleft_nxt = 8'd0;
              cprod_nxt = 64'd1;
              eleft_nxt = 64'd0;
              tag_nxt   = TAG_BOTH;
              pos_nxt   = 3'd0;
            end
          end else begin
            err = ERR_MARKER;
          end
        end
        PH_VERSION: begin
          if (in_data_byte == VERSION_2) begin
            ev        = EV_HEADER;
            phase_nxt = PH_RANK;
          end else begin
            err = ERR_VERSION;
          end
        end
        PH_RANK: begin
          rank_nxt  = in_data_byte;
          dleft_nxt = in_data_byte;
          pos_nxt   = 3'd0;
          tag_nxt   = TAG_BOTH;
          ev        = EV_HEADER;
          phase_nxt = PH_TAG;
        end
        PH_TAG: begin
          if (in_data_byte != TAG_INT[pos_r[1:0]]) tag_upd[0] = 1'b0;
          if (in_data_byte != TAG_FLT[pos_r[1:0]]) tag_upd[1] = 1'b0;
          tag_nxt = tag_upd;
          ev      = EV_HEADER;
          if (pos_r[1:0] == 2'd3) begin
            pos_nxt = 3'd0;
            if (tag_upd == 2'b00) begin
              err = ERR_TYPE;
            end else if (dleft_r == 8'd0) begin
              // scalar: one element follows the tag
              eleft_nxt  = 64'd1;
              eshift_nxt = 32'd0;
              phase_nxt  = PH_PAYLOAD;
            end else begin
              dshift_nxt = 64'd0;
              acc_nxt    = 64'd0;
              ovf_nxt    = 1'b0;
              phase_nxt  = PH_DIM;
            end
          end else begin
            pos_nxt = {1'b0, pos_r[1:0] + 2'd1};
          end
        end
        PH_DIM: begin
          if (pos_r != 3'd7) begin
            dshift_nxt = dim_val;
            acc_nxt    = acc_sum[63:0];
            ovf_nxt    = ovf_fin;
            pos_nxt    = pos_r + 3'd1;
            ev         = EV_HEADER;
          end else begin
            pos_nxt    = 3'd0;
            didx       = dleft_r - 8'd1;
            dsz        = dim_val;
            dshift_nxt = 64'd0;
            acc_nxt    = 64'd0;
            ovf_nxt    = 1'b0;
            dleft_nxt  = dleft_r - 8'd1;
            if (ovf_fin) begin
              cprod_nxt = '1;
              err       = ERR_OVERFLOW;
            end else begin
              cprod_nxt = acc_sum[63:0];
              ev        = EV_DIM_DONE;
              if (dleft_r == 8'd1) begin
                if (acc_sum[63:0] == 64'd0) begin
                  // empty variable: no payload
                  vdone     = 1'b1;
                  vcnt_nxt  = vcnt_r + VAR_W'(1);
                  phase_nxt = PH_IDLE;
                end else begin
                  eleft_nxt  = acc_sum[63:0];
                  eshift_nxt = 32'd0;
                  phase_nxt  = PH_PAYLOAD;
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (pos_r[1:0] != 2'd3) begin
            eshift_nxt = elem_val;
            pos_nxt    = {1'b0, pos_r[1:0] + 2'd1};
            ev         = EV_PAYLOAD;
          end else begin
            pos_nxt    = 3'd0;
            bits       = elem_val;
            eshift_nxt = 32'd0;
            ev         = EV_ELEM_DONE;
            eleft_nxt  = eleft_dec;
            if (eleft_dec == 64'd0) begin
              vdone     = 1'b1;
              vcnt_nxt  = vcnt_r + VAR_W'(1);
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (err == ERR_NONE && in_end_of_stream) begin
        if (phase_nxt == PH_IDLE) begin
          ev       = EV_STREAM;
          vn       = vcnt_nxt;
          vcnt_nxt = '0;
        end else begin
          err = ERR_TRUNCATED;
        end
      end
      if (err != ERR_NONE) begin
        lerr_nxt = err;
      end
    end else begin
      err = lerr_r;
    end

    if (err != ERR_NONE) begin
      ev    = EV_ERROR;
      vn    = vcnt_nxt;
      didx  = 8'd0;
      dsz   = 64'd0;
      bits  = 32'd0;
      vdone = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      lerr_r   <= ERR_NONE;
      pos_r    <= 3'd0;
      rank_r   <= 8'd0;
      dleft_r  <= 8'd0;
      dshift_r <= 64'd0;
      cprod_r  <= 64'd1;
      eleft_r  <= 64'd0;
      eshift_r <= 32'd0;
      tag_r    <= TAG_BOTH;
      vcnt_r   <= '0;
      acc_r    <= 64'd0;
      ovf_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      lerr_r   <= lerr_nxt;
      pos_r    <= pos_nxt;
      rank_r   <= rank_nxt;
      dleft_r  <= dleft_nxt;
      dshift_r <= dshift_nxt;
      cprod_r  <= cprod_nxt;
      eleft_r  <= eleft_nxt;
      eshift_r <= eshift_nxt;
      tag_r    <= tag_nxt;
      vcnt_r   <= vcnt_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r       <= ev;
      err_r      <= err;
      vn_r       <= vn;
      etype_r    <= (tag_nxt == TAG_FLT_ONLY);
      rank_out_r <= rank_nxt;
      didx_r     <= didx;
      dsz_r      <= dsz;
      bits_r     <= bits;
      total_r    <= cprod_nxt;
      vdone_r    <= vdone;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_code      = ev_r;
  assign out_error_code      = err_r;
  assign out_variable_number = vn_r;
  assign out_element_type    = etype_r;
  assign out_rank            = rank_out_r;
  assign out_dimension_index = didx_r;
  assign out_dimension_size  = dsz_r;
  assign out_element_bits    = bits_r;
  assign out_element_total   = total_r;
  assign out_variable_done   = vdone_r;

  // a latched error never changes until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (lerr_r != ERR_NONE) |=> (lerr_r == $past(lerr_r)))
    else $error("latched error changed");

  // error results always carry a code, other results never do
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((ev_r == EV_ERROR) == (err_r != ERR_NONE)))
    else $error("event and error code disagree");

  // a variable completes only on a dimension, element or stream-done result
  a_vdone_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && vdone_r) |->
      (ev_r == EV_DIM_DONE || ev_r == EV_ELEM_DONE || ev_r == EV_STREAM))
    else $error("variable done on wrong event");

  // the variable count never exceeds the limit
  a_vcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VAR_W'(MAX_VARIABLES))
    else $error("variable count above limit");

endmodule

@@ sim/binary_array_stream_parser_unit_tb.sv @@
// testbench for binary_array_stream_parser_unit: byte requests in, one parse event out per byte
// a scoreboard class predicts every event from its own copy of the parser state
// depends on basp_pkg and the parser rtl only
module binary_array_stream_parser_unit_tb
  import basp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_SCALAR = 0;
  localparam int KIND_EMPTY  = 1;
  localparam int KIND_GRID   = 2;
  localparam int KIND_WIDE   = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 350;

  typedef struct packed {
    logic [2:0]       ev;
    logic [2:0]       err;
    logic [VAR_W-1:0] var_num;
    logic             is_float;
    logic [7:0]       rank;
    logic [7:0]       dim_idx;
    logic [63:0]      dim_size;
    logic [31:0]      bits;
    logic [63:0]      total;
    logic             done;
  } parse_result_t;

  class parse_scoreboard;
    phase_t           phase;
    err_t             held_err;
    logic [2:0]       pos;
    logic [7:0]       rank_q;
    logic [7:0]       dims_left;
    logic [63:0]      dim_acc;
    logic [63:0]      total;
    logic [63:0]      elems_left;
    logic [31:0]      elem_acc;
    logic [1:0]       tag_ok;
    logic [VAR_W-1:0] var_count;
    parse_result_t    pending_q[$];
    int               checked;
    int               mismatches;
    int               streams_done;
    int               vars_done;

    function new();
      phase = PH_IDLE;
      held_err = ERR_NONE;
      pos = '0;
      rank_q = '0;
      dims_left = '0;
      dim_acc = '0;
      total = 64'd1;
      elems_left = '0;
      elem_acc = '0;
      tag_ok = TAG_BOTH;
      var_count = '0;
    endfunction

    function parse_result_t error_result(err_t e);
      parse_result_t r;
      r = '0;
      r.ev = EV_ERROR;
      r.err = e;
      r.var_num = var_count;
      r.is_float = (tag_ok == TAG_FLT_ONLY);
      r.rank = rank_q;
      r.total = total;
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      parse_result_t r;
      err_t e;
      logic [VAR_W-1:0] vn;
      logic [2:0] p;
      logic [63:0] d;
      logic [127:0] wide;
      r = '0;
      e = ERR_NONE;
      vn = var_count;
      p = pos;
      if (held_err != ERR_NONE) begin
        pending_q.push_back(error_result(held_err));
        return;
      end
      r.ev = EV_SKIP;
      case (phase)
        PH_IDLE: begin
          if (b == WS_SPACE || b == WS_NUL || b == WS_TAB || b == WS_NEWLINE) begin
            r.ev = EV_SKIP;
          end else if (b == MARKER_B) begin
            if (var_count >= MAX_VARIABLES) begin
              e = ERR_TOO_MANY;
            end else begin
              r.ev = EV_HEADER;
              phase = PH_VERSION;
              rank_q = '0;
              dims_left = '0;
              total = 64'd1;
              elems_left = '0;
              tag_ok = TAG_BOTH;
              pos = '0;
            end
          end else begin
            e = ERR_MARKER;
          end
        end
        PH_VERSION: begin
          if (b == VERSION_2) begin
            r.ev = EV_HEADER;
            phase = PH_RANK;
          end else begin
            e = ERR_VERSION;
          end
        end
        PH_RANK: begin
          rank_q = b;
          dims_left = b;
          pos = '0;
          tag_ok = TAG_BOTH;
          r.ev = EV_HEADER;
          phase = PH_TAG;
        end
        PH_TAG: begin
          p[2] = 1'b0;
          if (b != TAG_INT[p[1:0]]) tag_ok[0] = 1'b0;
          if (b != TAG_FLT[p[1:0]]) tag_ok[1] = 1'b0;
          r.ev = EV_HEADER;
          if (p == 3'd3) begin
            pos = '0;
            if (tag_ok == 2'b00) begin
              e = ERR_TYPE;
            end else if (dims_left == 0) begin
              // scalar: exactly one element follows the tag
              elems_left = 64'd1;
              elem_acc = '0;
              phase = PH_PAYLOAD;
            end else begin
              dim_acc = '0;
              phase = PH_DIM;
            end
          end else begin
            pos = p + 3'd1;
          end
        end
        PH_DIM: begin
          dim_acc = dim_acc | (64'(b) << (8 * p));
          if (p < 3'd7) begin
            pos = p + 3'd1;
            r.ev = EV_HEADER;
          end else begin
            pos = '0;
            d = dim_acc;
            r.dim_idx = dims_left - 8'd1;
            r.dim_size = d;
            dim_acc = '0;
            dims_left = dims_left - 8'd1;
            wide = 128'(total) * 128'(d);
            if (wide[127:64] != 0) begin
              total = '1;
              e = ERR_OVERFLOW;
            end else begin
              total = wide[63:0];
              r.ev = EV_DIM_DONE;
              if (dims_left == 0) begin
                if (total == 0) begin
                  // empty array: no payload at all
                  r.done = 1'b1;
                  var_count = var_count + 1'b1;
                  phase = PH_IDLE;
                end else begin
                  elems_left = total;
                  elem_acc = '0;
                  phase = PH_PAYLOAD;
                end
              end
            end
          end
        end
        default: begin
          p[2] = 1'b0;
          elem_acc = elem_acc | (32'(b) << (8 * p));
          if (p < 3'd3) begin
            pos = p + 3'd1;
            r.ev = EV_PAYLOAD;
          end else begin
            pos = '0;
            r.bits = elem_acc;
            elem_acc = '0;
            r.ev = EV_ELEM_DONE;
            elems_left = elems_left - 64'd1;
            if (elems_left == 0) begin
              r.done = 1'b1;
              var_count = var_count + 1'b1;
              phase = PH_IDLE;
            end
          end
        end
      endcase
      if (e == ERR_NONE && eos) begin
        if (phase == PH_IDLE) begin
          r.ev = EV_STREAM;
          vn = var_count;
          var_count = '0;
        end else begin
          e = ERR_TRUNCATED;
        end
      end
      if (e != ERR_NONE) begin
        held_err = e;
        pending_q.push_back(error_result(e));
        return;
      end
      r.err = ERR_NONE;
      r.var_num = vn;
      r.is_float = (tag_ok == TAG_FLT_ONLY);
      r.rank = rank_q;
      r.total = total;
      pending_q.push_back(r);
    endfunction

    function string show(parse_result_t r);
      return {$sformatf("ev=%0d err=%0d var=%0d flt=%0d rank=%0d ",
                        r.ev, r.err, r.var_num, r.is_float, r.rank),
              $sformatf("didx=%0d dsz=%h bits=%h tot=%h done=%0d",
                        r.dim_idx, r.dim_size, r.bits, r.total, r.done)};
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: %s", $time, show(got));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch on result %0d", $time, checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
      if (want.ev == EV_STREAM) streams_done++;
      if (want.done) vars_done++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_event_code;
  logic [2:0]        out_error_code;
  logic [VAR_W-1:0]  out_variable_number;
  logic              out_element_type;
  logic [7:0]        out_rank;
  logic [7:0]        out_dimension_index;
  logic [63:0]       out_dimension_size;
  logic [31:0]       out_element_bits;
  logic [63:0]       out_element_total;
  logic              out_variable_done;

  parse_scoreboard book = new();
  parse_result_t   seen;
  int              sent;
  int              holds;
  bit              hold_req;
  bit              calm;
  err_t            err_kind;

  binary_array_stream_parser_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_code      (out_event_code),
    .out_error_code      (out_error_code),
    .out_variable_number (out_variable_number),
    .out_element_type    (out_element_type),
    .out_rank            (out_rank),
    .out_dimension_index (out_dimension_index),
    .out_dimension_size  (out_dimension_size),
    .out_element_bits    (out_element_bits),
    .out_element_total   (out_element_total),
    .out_variable_done   (out_variable_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 3))
      0: return WS_SPACE;
      1: return WS_NUL;
      2: return WS_TAB;
      default: return WS_NEWLINE;
    endcase
  endfunction

  function automatic void pick_dims(input int kind, output logic [7:0] rnk,
                                    output logic [63:0] dims[$]);
    int z;
    dims = {};
    case (kind)
      KIND_SCALAR: rnk = 8'd0;
      KIND_GRID: begin
        rnk = 8'($urandom_range(1, 3));
        for (int i = 0; i < rnk; i++) dims.push_back(64'($urandom_range(1, 3)));
      end
      default: begin
        // a zero size empties the array, so sizes after it may be anything
        rnk = (kind == KIND_WIDE) ? 8'd24 : 8'($urandom_range(1, 4));
        z = (kind == KIND_WIDE) ? 0 : $urandom_range(0, rnk - 1);
        for (int i = 0; i < rnk; i++) begin
          if (i < z) dims.push_back(64'($urandom_range(1, 3)));
          else if (i == z) dims.push_back(64'd0);
          else dims.push_back({$urandom, $urandom});
        end
      end
    endcase
  endfunction

  function automatic void build_variable(input logic [7:0] rnk, input logic [63:0] dims[$],
                                         input bit flt, output logic [7:0] bq[$]);
    logic [63:0]  count;
    logic [127:0] wide;
    logic [31:0]  w;
    bit           fits;
    bq = {};
    bq.push_back(MARKER_B);
    bq.push_back(VERSION_2);
    bq.push_back(rnk);
    for (int i = 0; i < 4; i++) bq.push_back(flt ? TAG_FLT[i] : TAG_INT[i]);
    count = 64'd1;
    fits = 1'b1;
    foreach (dims[i]) begin
      for (int j = 0; j < 8; j++) bq.push_back(dims[i][8*j +: 8]);
      wide = 128'(count) * 128'(dims[i]);
      if (wide[127:64] != 0) fits = 1'b0;
      count = wide[63:0];
    end
    if (!fits) count = '0;
    for (logic [63:0] n = 0; n < count; n++) begin
      w = $urandom;
      for (int j = 0; j < 4; j++) bq.push_back(w[8*j +: 8]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(b, last);
    sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bq[$], input int eos_idx);
    foreach (bq[i]) send_byte(bq[i], i == eos_idx);
  endtask

  // one stream: whitespace, a few arrays, then the end mark
  task automatic send_stream(input int nvars, input bit compact);
    logic [7:0]  rnk;
    logic [63:0] dims[$];
    logic [7:0]  bq[$];
    bit          ws_end;
    int          r;
    int          kind;
    ws_end = (nvars == 0) || ($urandom_range(0, 2) == 0);
    for (int v = 0; v < nvars; v++) begin
      repeat ($urandom_range(0, 2)) send_byte(pick_ws(), 1'b0);
      r = $urandom_range(0, 9);
      if (compact) kind = (r < 5) ? KIND_SCALAR : KIND_EMPTY;
      else kind = (r < 2) ? KIND_SCALAR : (r < 4) ? KIND_EMPTY : KIND_GRID;
      pick_dims(kind, rnk, dims);
      build_variable(rnk, dims, 1'($urandom_range(0, 1)), bq);
      send_bytes(bq, (v == nvars - 1 && !ws_end) ? bq.size() - 1 : -1);
    end
    if (ws_end) send_byte(pick_ws(), 1'b1);
  endtask

  initial begin
    int          stall_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holds++;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = next_gap();
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.ev       = out_event_code;
      seen.err      = out_error_code;
      seen.var_num  = out_variable_number;
      seen.is_float = out_element_type;
      seen.rank     = out_rank;
      seen.dim_idx  = out_dimension_index;
      seen.dim_size = out_dimension_size;
      seen.bits     = out_element_bits;
      seen.total    = out_element_total;
      seen.done     = out_variable_done;
      book.check_result(seen);
    end
  end

  initial begin
    logic [7:0]  rnk;
    logic [63:0] dims[$];
    logic [7:0]  bq[$];
    logic [7:0]  b;
    int          streams;
    int          p;
    int          waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_stream = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every separator, an all-ones float scalar, an empty array ending the stream
    send_byte(WS_SPACE, 1'b0);
    send_byte(WS_NUL, 1'b0);
    send_byte(WS_TAB, 1'b0);
    send_byte(WS_NEWLINE, 1'b0);
    dims = {};
    build_variable(8'd0, dims, 1'b1, bq);
    for (int k = 7; k < 11; k++) bq[k] = 8'hff;
    send_bytes(bq, -1);
    dims = {64'd0};
    build_variable(8'd1, dims, 1'b0, bq);
    send_bytes(bq, bq.size() - 1);

    // a full stream of the maximum variable count, then a high rank with a zero first size
    send_stream(MAX_VARIABLES, 1'b1);
    pick_dims(KIND_WIDE, rnk, dims);
    build_variable(rnk, dims, 1'($urandom_range(0, 1)), bq);
    send_bytes(bq, bq.size() - 1);

    streams = 0;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      calm = (streams % 7 == 3);
      if (streams == 0) hold_req = 1'b1;
      send_stream($urandom_range(0, 4), 1'b0);
      streams++;
    end
    calm = 1'b0;

    // errors latch until reset, so the run closes with one of them
    err_kind = err_t'($urandom_range(ERR_MARKER, ERR_OVERFLOW));
    case (err_kind)
      ERR_MARKER: begin
        do b = 8'($urandom);
        while (b == WS_SPACE || b == WS_NUL || b == WS_TAB || b == WS_NEWLINE || b == MARKER_B);
        send_byte(b, 1'b0);
      end
      ERR_VERSION: begin
        send_byte(MARKER_B, 1'b0);
        do b = 8'($urandom); while (b == VERSION_2);
        send_byte(b, 1'b0);
      end
      ERR_TYPE: begin
        pick_dims(KIND_GRID, rnk, dims);
        build_variable(rnk, dims, 1'($urandom_range(0, 1)), bq);
        p = $urandom_range(0, 3);
        do b = 8'($urandom); while (b == TAG_INT[p] || b == TAG_FLT[p]);
        bq[3 + p] = b;
        send_bytes(bq, -1);
      end
      ERR_TRUNCATED: begin
        pick_dims($urandom_range(KIND_SCALAR, KIND_GRID), rnk, dims);
        build_variable(rnk, dims, 1'($urandom_range(0, 1)), bq);
        send_bytes(bq, $urandom_range(0, bq.size() - 2));
      end
      ERR_TOO_MANY: begin
        for (int v = 0; v < MAX_VARIABLES; v++) begin
          pick_dims($urandom_range(KIND_SCALAR, KIND_EMPTY), rnk, dims);
          build_variable(rnk, dims, 1'($urandom_range(0, 1)), bq);
          send_bytes(bq, -1);
        end
        send_byte(MARKER_B, 1'b0);
      end
      default: begin
        dims = {{1'b1, 31'($urandom), $urandom}, {$urandom, $urandom} | 64'h2};
        build_variable(8'd2, dims, 1'($urandom_range(0, 1)), bq);
        send_bytes(bq, -1);
      end
    endcase
    repeat (16) send_byte(8'($urandom), 1'($urandom_range(0, 1)));

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (book.pending_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (book.pending_q.size() != 0)
      $display("%0d expected results never arrived", book.pending_q.size());

    $display("checked %0d results: %0d finished arrays over %0d stream ends",
             book.checked, book.vars_done, book.streams_done);
    $display("closed on a latched %s error; %0d long output hold(s) backed up the input",
             err_kind.name(), holds);
    if (book.mismatches == 0 && book.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
